FILE: rtl/glu_pkg.sv
// Shared constants, pipeline item types and step functions for the GCD/LCM unit.
package glu_pkg;

    localparam int OPERAND_WIDTH  = 16;
    localparam int FIELD_WIDTH    = 16;
    localparam int MULTIPLE_WIDTH = 32;
    localparam int SHIFT_WIDTH    = $clog2(OPERAND_WIDTH);
    localparam int GCD_STEPS      = 2 * OPERAND_WIDTH;
    localparam int DIV_STEPS      = OPERAND_WIDTH;

    typedef logic [OPERAND_WIDTH-1:0]   operand_t;
    typedef logic [2*OPERAND_WIDTH-1:0] product_t;

    typedef struct packed {
        operand_t               u;
        operand_t               v;
        logic [SHIFT_WIDTH-1:0] k;
        operand_t               a;
        operand_t               b;
    } gcd_state_t;

    typedef struct packed {
        operand_t rem;
        operand_t dq;
        operand_t g;
        operand_t b;
    } div_state_t;

    // One binary GCD step; holds once either value is zero.
    function automatic gcd_state_t gcd_step(gcd_state_t s);
        gcd_state_t n;
        n = s;
        if (s.u != '0 && s.v != '0) begin
            case ({s.u[0], s.v[0]})
                2'b00: begin
                    n.u = s.u >> 1;
                    n.v = s.v >> 1;
                    n.k = s.k + 1'b1;
                end
                2'b01: begin
                    n.u = s.u >> 1;
                end
                2'b10: begin
                    n.v = s.v >> 1;
                end
                default: begin
                    if (s.u >= s.v) begin
                        n.u = (s.u - s.v) >> 1;
                    end else begin
                        n.v = (s.v - s.u) >> 1;
                    end
                end
            endcase
        end
        return n;
    endfunction

    // One restoring division step: next quotient bit into dq.
    function automatic div_state_t div_step(div_state_t s);
        div_state_t             n;
        logic [OPERAND_WIDTH:0] trial;
        logic [OPERAND_WIDTH:0] diff;
        n     = s;
        trial = {s.rem, s.dq[OPERAND_WIDTH-1]};
        diff  = trial - {1'b0, s.g};
        if (trial >= {1'b0, s.g}) begin
            n.rem = diff[OPERAND_WIDTH-1:0];
            n.dq  = {s.dq[OPERAND_WIDTH-2:0], 1'b1};
        end else begin
            n.rem = trial[OPERAND_WIDTH-1:0];
            n.dq  = {s.dq[OPERAND_WIDTH-2:0], 1'b0};
        end
        return n;
    endfunction

endpackage

FILE: rtl/glu_gcd_pipe.sv
// Binary GCD pipeline: one reduction step per register stage.
module glu_gcd_pipe (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  glu_pkg::gcd_state_t in_state,
    output logic                out_valid,
    output glu_pkg::gcd_state_t out_state
);

    logic                valid_reg [glu_pkg::GCD_STEPS];
    glu_pkg::gcd_state_t state_reg [glu_pkg::GCD_STEPS];

    for (genvar i = 0; i < glu_pkg::GCD_STEPS; i++) begin : g_stage
        logic                prev_valid;
        glu_pkg::gcd_state_t prev_state;
        glu_pkg::gcd_state_t state_next;

        if (i == 0) begin : g_first
            assign prev_valid = in_valid;
            assign prev_state = in_state;
        end else begin : g_rest
            assign prev_valid = valid_reg[i-1];
            assign prev_state = state_reg[i-1];
        end

        assign state_next = glu_pkg::gcd_step(prev_state);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (en) begin
                valid_reg[i] <= prev_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                state_reg[i] <= state_next;
            end
        end
    end

    assign out_valid = valid_reg[glu_pkg::GCD_STEPS-1];
    assign out_state = state_reg[glu_pkg::GCD_STEPS-1];

`ifndef ASSERT_OFF
    // reduction must have finished by the last stage
    a_gcd_done: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (out_state.u == '0 || out_state.v == '0))
        else $error("gcd reduction not finished at pipe end");
`endif

endmodule

FILE: rtl/glu_div_pipe.sv
// Restoring divider pipeline: one quotient bit per register stage.
module glu_div_pipe (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  glu_pkg::div_state_t in_state,
    output logic                out_valid,
    output glu_pkg::div_state_t out_state
);

    logic                valid_reg [glu_pkg::DIV_STEPS];
    glu_pkg::div_state_t state_reg [glu_pkg::DIV_STEPS];

    for (genvar i = 0; i < glu_pkg::DIV_STEPS; i++) begin : g_stage
        logic                prev_valid;
        glu_pkg::div_state_t prev_state;
        glu_pkg::div_state_t state_next;

        if (i == 0) begin : g_first
            assign prev_valid = in_valid;
            assign prev_state = in_state;
        end else begin : g_rest
            assign prev_valid = valid_reg[i-1];
            assign prev_state = state_reg[i-1];
        end

        assign state_next = glu_pkg::div_step(prev_state);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (en) begin
                valid_reg[i] <= prev_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                state_reg[i] <= state_next;
            end
        end
    end

    assign out_valid = valid_reg[glu_pkg::DIV_STEPS-1];
    assign out_state = state_reg[glu_pkg::DIV_STEPS-1];

`ifndef ASSERT_OFF
    // remainder stays below a nonzero divisor
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && out_state.g != '0) |-> (out_state.rem < out_state.g))
        else $error("divider remainder not below divisor");
`endif

endmodule

FILE: rtl/gcd_lcm_unit.sv
// Top level of the GCD/LCM unit: handshake, GCD pipe, divider pipe, multiplier.
// Returns gcd(a,b) and lcm(a,b) = (a / gcd) * b for each request, exact; the
// multiple is 0 when either operand is zero, and the divisor is 0 when both
// are. Fully pipelined: one request per cycle enters whenever the output
// register is empty or being taken. Each request passes the binary GCD chain (2*W
// stages), one normalize stage, the restoring divider (W stages) and the
// registered multiplier. A stall at the output freezes every stage at once.
module gcd_lcm_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_operand_a,
    input  logic [15:0] s_operand_b,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_common_divisor,
    output logic [31:0] m_common_multiple
);

    logic                en;
    glu_pkg::gcd_state_t gcd_in;
    logic                gcd_out_valid;
    glu_pkg::gcd_state_t gcd_out;
    logic                norm_valid_reg;
    glu_pkg::div_state_t norm_state_reg;
    glu_pkg::div_state_t norm_next;
    logic                div_out_valid;
    glu_pkg::div_state_t div_out;
    glu_pkg::product_t   prod_next;
    logic                m_valid_reg;
    logic [15:0]         m_divisor_reg;
    logic [31:0]         m_multiple_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    always_comb begin
        gcd_in.a = glu_pkg::operand_t'(s_operand_a);
        gcd_in.b = glu_pkg::operand_t'(s_operand_b);
        gcd_in.u = gcd_in.a;
        gcd_in.v = gcd_in.b;
        gcd_in.k = '0;
    end

    glu_gcd_pipe u_gcd (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_state  (gcd_in),
        .out_valid (gcd_out_valid),
        .out_state (gcd_out)
    );

    // restore common power of two, load divider
    always_comb begin
        norm_next.rem = '0;
        norm_next.dq  = gcd_out.a;
        norm_next.g   = (gcd_out.u | gcd_out.v) << gcd_out.k;
        norm_next.b   = gcd_out.b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            norm_valid_reg <= 1'b0;
        end else if (en) begin
            norm_valid_reg <= gcd_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            norm_state_reg <= norm_next;
        end
    end

    glu_div_pipe u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (norm_valid_reg),
        .in_state  (norm_state_reg),
        .out_valid (div_out_valid),
        .out_state (div_out)
    );

    assign prod_next = div_out.dq * div_out.b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= div_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_divisor_reg  <= 16'(div_out.g);
            m_multiple_reg <= 32'(prod_next);
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_common_divisor  = m_divisor_reg;
    assign m_common_multiple = m_multiple_reg;

`ifndef ASSERT_OFF
    a_zero_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_divisor_reg == '0) |-> (m_multiple_reg == '0))
        else $error("zero divisor with nonzero multiple");

    a_lcm_ge_gcd: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_multiple_reg != '0)
            |-> (m_multiple_reg >= {16'd0, m_divisor_reg}))
        else $error("multiple below divisor");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(m_multiple_reg)))
        else $error("pending result changed during stall");
`endif

endmodule
